// ===== hdl/smic_pkg.sv =====
// Shared constants and types for the sorted multiset intersection counter.
package smic_pkg;

   localparam int LIST_DEPTH  = 64;
   localparam int KEY_WIDTH   = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int TOTAL_WIDTH = 22;
   localparam int ADDR_WIDTH  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int FILL_WIDTH  = $clog2(LIST_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_APPEND_A = 2'd0,
      OP_APPEND_B = 2'd1,
      OP_COMPUTE  = 2'd2
   } op_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]   key;
      logic [COUNT_WIDTH-1:0] count;
   } entry_type;

   typedef struct packed {
      logic                   adv_a;
      logic                   adv_b;
      logic [TOTAL_WIDTH-1:0] sum;
   } step_type;

endpackage

// ===== hdl/sorted_multiset_intersection_count.sv =====
// Top level of the sorted multiset intersection counter.
//
// Requests arrive on the req_ channel as valid/ready transfers. Operation
// append A or append B stores one (key, count) entry at the end of that
// list; an append to a full list is dropped and sets a sticky overflow flag.
// Appends are taken one per cycle while idle and produce no response.
// Operation compute walks both lists with two pointers, one merge step per
// cycle, since each step reads the next entries from the list memories.
// A compute occupies the block through its merge steps and a finishing
// step; req_ready is low during that time.
// The compute then writes one response into the rsp_ output register and
// empties both lists and the overflow flag. Appends are taken while that
// response waits. If the previous response has not been taken yet, the
// compute holds in its finishing cycle until it is.
// Synchronous reset empties both lists, clears the overflow flag and drops
// any pending response. Unused operation codes are accepted and ignored.
module sorted_multiset_intersection_count
   import smic_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_operation,
   input  logic [15:0]            req_entry_key,
   input  logic [15:0]            req_entry_count,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [TOTAL_WIDTH-1:0] rsp_common_total,
   output logic                   rsp_list_overflow
);

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type              state_ff, state_in;
   logic [FILL_WIDTH-1:0]  fill_a_ff, fill_a_in;
   logic [FILL_WIDTH-1:0]  fill_b_ff, fill_b_in;
   logic                   overflow_ff, overflow_in;
   logic [FILL_WIDTH-1:0]  ia_ff, ia_in;
   logic [FILL_WIDTH-1:0]  ib_ff, ib_in;
   logic [TOTAL_WIDTH-1:0] sum_ff, sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_WIDTH-1:0] rsp_total_ff, rsp_total_in;
   logic                   rsp_overflow_ff, rsp_overflow_in;

   logic      req_xfer;
   logic      wr_en_a, wr_en_b;
   logic      finish;
   entry_type wr_entry;
   entry_type rd_entry_a, rd_entry_b;
   step_type  step;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign wr_entry.key   = req_entry_key[KEY_WIDTH-1:0];
   assign wr_entry.count = req_entry_count[COUNT_WIDTH-1:0];
   assign wr_en_a = req_xfer && (req_operation == OP_APPEND_A)
                    && (fill_a_ff < FILL_WIDTH'(LIST_DEPTH));
   assign wr_en_b = req_xfer && (req_operation == OP_APPEND_B)
                    && (fill_b_ff < FILL_WIDTH'(LIST_DEPTH));

   smic_list_mem u_list_a (
      .clock    (clock),
      .wr_en    (wr_en_a),
      .wr_addr  (fill_a_ff[ADDR_WIDTH-1:0]),
      .wr_entry (wr_entry),
      .rd_addr  (ia_in[ADDR_WIDTH-1:0]),
      .rd_entry (rd_entry_a)
   );

   smic_list_mem u_list_b (
      .clock    (clock),
      .wr_en    (wr_en_b),
      .wr_addr  (fill_b_ff[ADDR_WIDTH-1:0]),
      .wr_entry (wr_entry),
      .rd_addr  (ib_in[ADDR_WIDTH-1:0]),
      .rd_entry (rd_entry_b)
   );

   smic_merge_unit u_merge (
      .entry_a (rd_entry_a),
      .entry_b (rd_entry_b),
      .sum_in  (sum_ff),
      .step    (step)
   );

   always_comb begin
      state_in        = state_ff;
      fill_a_in       = fill_a_ff;
      fill_b_in       = fill_b_ff;
      overflow_in     = overflow_ff;
      ia_in           = ia_ff;
      ib_in           = ib_ff;
      sum_in          = sum_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_total_in    = rsp_total_ff;
      rsp_overflow_in = rsp_overflow_ff;
      finish          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ia_in  = '0;
            ib_in  = '0;
            sum_in = '0;
            if (req_xfer) begin
               case (req_operation)
                  OP_APPEND_A: begin
                     if (wr_en_a) begin
                        fill_a_in = fill_a_ff + FILL_WIDTH'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  OP_APPEND_B: begin
                     if (wr_en_b) begin
                        fill_b_in = fill_b_ff + FILL_WIDTH'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  OP_COMPUTE: begin
                     state_in = ST_MERGE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            if ((ia_ff < fill_a_ff) && (ib_ff < fill_b_ff)) begin
               ia_in  = ia_ff + FILL_WIDTH'(step.adv_a);
               ib_in  = ib_ff + FILL_WIDTH'(step.adv_b);
               sum_in = step.sum;
            end else if (!rsp_valid_ff || rsp_ready) begin
               finish          = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_total_in    = sum_ff;
               rsp_overflow_in = overflow_ff;
               fill_a_in       = '0;
               fill_b_in       = '0;
               overflow_in     = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_a_ff    <= '0;
         fill_b_ff    <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_a_ff    <= fill_a_in;
         fill_b_ff    <= fill_b_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ia_ff           <= ia_in;
      ib_ff           <= ib_in;
      sum_ff          <= sum_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_common_total  = rsp_total_ff;
   assign rsp_list_overflow = rsp_overflow_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (ia_ff <= fill_a_ff) && (ib_ff <= fill_b_ff))
      else $error("Merge pointer ran past its list fill.");

   assert property (@(posedge clock) disable iff (reset)
      (fill_a_ff <= FILL_WIDTH'(LIST_DEPTH)) && (fill_b_ff <= FILL_WIDTH'(LIST_DEPTH)))
      else $error("List fill exceeds the list depth.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) && ($past(state_ff) == ST_MERGE) |-> (sum_ff >= $past(sum_ff)))
      else $error("Running total decreased during a merge.");

   assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid && (fill_a_ff == '0) && (fill_b_ff == '0) && !overflow_ff)
      else $error("Compute finish did not post a response and empty the lists.");

endmodule

// ===== hdl/smic_list_mem.sv =====
// Entry store of one list: one write port and one registered read port.
module smic_list_mem
   import smic_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  entry_type             wr_entry,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output entry_type             rd_entry
);

   entry_type mem_ff [LIST_DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== hdl/smic_merge_unit.sv =====
// Shared merge step: key compare, count minimum and saturating accumulate.
module smic_merge_unit
   import smic_pkg::*;
(
   input  entry_type              entry_a,
   input  entry_type              entry_b,
   input  logic [TOTAL_WIDTH-1:0] sum_in,
   output step_type               step
);

   logic                   keys_equal;
   logic [COUNT_WIDTH-1:0] count_min;
   logic [TOTAL_WIDTH:0]   sum_wide;

   always_comb begin
      keys_equal = (entry_a.key == entry_b.key);
      count_min  = (entry_a.count < entry_b.count) ? entry_a.count : entry_b.count;
      sum_wide   = {1'b0, sum_in} + (TOTAL_WIDTH + 1)'(count_min);
      step.adv_a = keys_equal || (entry_a.key < entry_b.key);
      step.adv_b = keys_equal || (entry_a.key > entry_b.key);
      if (!keys_equal) begin
         step.sum = sum_in;
      end else if (sum_wide[TOTAL_WIDTH]) begin
         step.sum = '1;
      end else begin
         step.sum = sum_wide[TOTAL_WIDTH-1:0];
      end
   end

endmodule

// ===== tb/sorted_multiset_intersection_count_tb.sv =====
// Self-checking testbench for the sorted multiset intersection counter.
`timescale 1ns / 1ps

module sorted_multiset_intersection_count_tb
   import smic_pkg::*;
();

   localparam logic [1:0] OP_UNUSED       = 2'd3;
   localparam longint     TOTAL_LIMIT     = (longint'(1) << TOTAL_WIDTH) - 1;
   localparam int         HOLD_OFF_CYCLES = 300;
   localparam int         STALL_LIMIT     = 4000;
   localparam int         PHASE_ITEMS     = 320;
   localparam int         SHAPE_RANDOM    = 0;
   localparam int         SHAPE_FULL      = 1;
   localparam int         SHAPE_OVERFLOW  = 2;

   typedef struct {
      logic [TOTAL_WIDTH-1:0] total;
      logic                   overflow;
   } outcome_type;

   class intersection_scoreboard;
      logic [KEY_WIDTH-1:0]   keys_a[LIST_DEPTH];
      logic [COUNT_WIDTH-1:0] counts_a[LIST_DEPTH];
      logic [KEY_WIDTH-1:0]   keys_b[LIST_DEPTH];
      logic [COUNT_WIDTH-1:0] counts_b[LIST_DEPTH];
      int                     fill_a;
      int                     fill_b;
      bit                     dropped;
      outcome_type            outcomes_due[$];
      int                     mismatches;

      function logic [TOTAL_WIDTH-1:0] merged_total();
         longint sum;
         int     ia;
         int     ib;
         sum = 0;
         ia = 0;
         ib = 0;
         while (ia < fill_a && ib < fill_b) begin
            if (keys_a[ia] == keys_b[ib]) begin
               sum += (counts_a[ia] < counts_b[ib]) ? counts_a[ia] : counts_b[ib];
               if (sum > TOTAL_LIMIT) sum = TOTAL_LIMIT;
               ia++;
               ib++;
            end else if (keys_a[ia] < keys_b[ib]) begin
               ia++;
            end else begin
               ib++;
            end
         end
         return sum[TOTAL_WIDTH-1:0];
      endfunction

      function void note_request(logic [1:0] op, logic [15:0] key, logic [15:0] count);
         outcome_type due;
         case (op)
            OP_APPEND_A: begin
               if (fill_a >= LIST_DEPTH) begin
                  dropped = 1'b1;
               end else begin
                  keys_a[fill_a] = key[KEY_WIDTH-1:0];
                  counts_a[fill_a] = count[COUNT_WIDTH-1:0];
                  fill_a++;
               end
            end
            OP_APPEND_B: begin
               if (fill_b >= LIST_DEPTH) begin
                  dropped = 1'b1;
               end else begin
                  keys_b[fill_b] = key[KEY_WIDTH-1:0];
                  counts_b[fill_b] = count[COUNT_WIDTH-1:0];
                  fill_b++;
               end
            end
            OP_COMPUTE: begin
               due.total = merged_total();
               due.overflow = dropped;
               outcomes_due.insert(outcomes_due.size(), due);
               fill_a = 0;
               fill_b = 0;
               dropped = 1'b0;
            end
            default: begin
            end
         endcase
      endfunction

      function void check_response(logic [TOTAL_WIDTH-1:0] total, logic overflow);
         outcome_type want;
         if (outcomes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response total=%0d overflow=%0b", total, overflow);
         end else begin
            want = outcomes_due.pop_front();
            if (total !== want.total || overflow !== want.overflow) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: expected total=%0d overflow=%0b, got total=%0d overflow=%0b",
                           want.total, want.overflow, total, overflow);
            end
         end
      endfunction

      function int pending();
         return outcomes_due.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_operation = OP_UNUSED;
   logic [15:0]            req_entry_key = '0;
   logic [15:0]            req_entry_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [TOTAL_WIDTH-1:0] rsp_common_total;
   logic                   rsp_list_overflow;

   intersection_scoreboard sb = new();
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   bit hold_off_request = 1'b0;
   int items_sent = 0;
   int idle_cycles = 0;

   sorted_multiset_intersection_count u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_entry_key     (req_entry_key),
      .req_entry_count   (req_entry_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_common_total  (rsp_common_total),
      .rsp_list_overflow (rsp_list_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_common_total, rsp_list_overflow);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("sorted_multiset_intersection_count verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // A hold-off keeps the response side stalled long enough for the request side to back up.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [15:0] key,
                            input logic [15:0] count);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         req_operation <= 2'($urandom_range(0, 3));
         req_entry_key <= 16'($urandom_range(0, 65535));
         req_entry_count <= 16'($urandom_range(0, 65535));
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_entry_key <= key;
      req_entry_count <= count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, key, count);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 3))
         0: return 16'hffff;
         1: return 16'($urandom_range(0, 3));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_noise_burst();
      repeat ($urandom_range(1, 6))
         send_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
   endtask

   // Builds two ascending key lists from a shared pool so that many keys match, appends them and requests a compute.
   task automatic run_histogram_pair(input int shape);
      int          pool_size;
      int          span;
      int          ia;
      int          ib;
      int          pick;
      int          offsets[$];
      logic [15:0] base;
      logic [15:0] tmp;
      logic [15:0] a_keys[$];
      logic [15:0] b_keys[$];
      bit          saturate_counts;

      saturate_counts = 1'b0;
      if (shape == SHAPE_RANDOM) begin
         pick = $urandom_range(0, 39);
         shape = (pick == 0) ? SHAPE_FULL : (pick == 1) ? SHAPE_OVERFLOW : SHAPE_RANDOM;
      end
      case (shape)
         SHAPE_FULL: begin
            pool_size = LIST_DEPTH;
            saturate_counts = $urandom_range(0, 1);
         end
         SHAPE_OVERFLOW: pool_size = 100;
         default: pool_size = $urandom_range(0, 24);
      endcase

      span = 0;
      for (int i = 0; i < pool_size; i++) begin
         span += $urandom_range(1, 3);
         offsets.insert(offsets.size(), span);
      end
      case ($urandom_range(0, 7))
         0: base = 16'd0;
         1: base = 16'(65535 - span);
         default: base = 16'($urandom_range(0, 65535 - span));
      endcase

      foreach (offsets[i]) begin
         pick = (shape == SHAPE_FULL) ? 2 : $urandom_range(0, 3);
         if (pick != 1) a_keys.insert(a_keys.size(), base + 16'(offsets[i]) - 16'd1);
         if (pick != 0) b_keys.insert(b_keys.size(), base + 16'(offsets[i]) - 16'd1);
      end

      // Occasionally break the ordering or repeat a key.
      if ($urandom_range(0, 9) == 0 && a_keys.size() > 1) begin
         ia = $urandom_range(0, a_keys.size() - 1);
         ib = $urandom_range(0, a_keys.size() - 1);
         tmp = a_keys[ia];
         a_keys[ia] = a_keys[ib];
         a_keys[ib] = tmp;
      end
      if ($urandom_range(0, 9) == 0 && b_keys.size() > 1) begin
         ib = $urandom_range(1, b_keys.size() - 1);
         b_keys[ib] = b_keys[ib-1];
      end

      ia = 0;
      ib = 0;
      while (ia < a_keys.size() || ib < b_keys.size()) begin
         if (ib >= b_keys.size() || (ia < a_keys.size() && $urandom_range(0, 1) == 0)) begin
            send_item(OP_APPEND_A, a_keys[ia], saturate_counts ? 16'hffff : pick_count());
            ia++;
         end else begin
            send_item(OP_APPEND_B, b_keys[ib], saturate_counts ? 16'hffff : pick_count());
            ib++;
         end
      end
      if ($urandom_range(0, 7) == 0)
         send_item(OP_UNUSED, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      send_item(OP_COMPUTE, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
   endtask

   initial begin
      int target;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty lists.
      send_item(OP_COMPUTE, 16'h0000, 16'h0000);
      // Key and count extremes.
      send_item(OP_APPEND_A, 16'h0000, 16'h0000);
      send_item(OP_APPEND_A, 16'hffff, 16'hffff);
      send_item(OP_APPEND_B, 16'h0000, 16'h0005);
      send_item(OP_APPEND_B, 16'hffff, 16'hffff);
      send_item(OP_COMPUTE, 16'hffff, 16'hffff);
      // One list empty, with an ignored operation in between.
      send_item(OP_APPEND_B, 16'h0007, 16'h000a);
      send_item(OP_UNUSED, 16'hffff, 16'hffff);
      send_item(OP_COMPUTE, 16'h5555, 16'haaaa);
      // Unsorted keys.
      send_item(OP_APPEND_A, 16'h0005, 16'h0003);
      send_item(OP_APPEND_A, 16'h0002, 16'h0004);
      send_item(OP_APPEND_B, 16'h0002, 16'h0009);
      send_item(OP_APPEND_B, 16'h0005, 16'h0001);
      send_item(OP_COMPUTE, 16'haaaa, 16'h5555);
      // Repeated keys.
      send_item(OP_APPEND_A, 16'h0009, 16'h0002);
      send_item(OP_APPEND_A, 16'h0009, 16'h0002);
      send_item(OP_APPEND_B, 16'h0009, 16'h0001);
      send_item(OP_APPEND_B, 16'h0009, 16'h0005);
      send_item(OP_COMPUTE, 16'h0000, 16'h0000);

      hold_off_request = 1'b1;
      run_histogram_pair(SHAPE_FULL);
      run_histogram_pair(SHAPE_OVERFLOW);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
            default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
         endcase
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(0, 11) == 0)
               send_noise_burst();
            else
               run_histogram_pair(SHAPE_RANDOM);
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * LIST_DEPTH + 8) @(posedge clock);
      if (sb.mismatches == 0)
         $display("sorted_multiset_intersection_count verification clean");
      else
         $display("sorted_multiset_intersection_count verification failed");
      $finish;
   end

endmodule
